// ===== src/rgb_min_max_normalizer_assert.svh =====
// Assertion macros used by the normalizer RTL.
`ifndef RGB_MIN_MAX_NORMALIZER_ASSERT_SVH
`define RGB_MIN_MAX_NORMALIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define RMN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmn assertion failed");
// Next-cycle implication, checked outside reset
`define RMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmn assertion failed");
`else
`define RMN_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RMN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/rmn_pkg.sv =====
// Shared constants and types for the min/max normalizer.
package rmn_pkg;

  localparam int MAX_PIXELS = 4096;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_W      = 8;
  localparam int CHANNELS   = 3;
  localparam int DATA_W     = PIX_W * CHANNELS;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS  = PIX_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] CH_FULL = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } rmn_op_t;

  typedef logic [PIX_W-1:0] rmn_pix_t;

  // One fetched pixel with the image statistics it is stretched against
  typedef struct packed {
    logic                       last;
    logic [CHANNELS-1:0][PIX_W-1:0] v;
    logic [CHANNELS-1:0][PIX_W-1:0] lo;
    logic [CHANNELS-1:0][PIX_W-1:0] hi;
  } rmn_job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } rmn_qstat_t;

endpackage

// ===== src/rmn_fifo.sv =====
// Short job queue between the front and back parts.
module rmn_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmn_pkg::rmn_job_t push_data,
  input  logic              pop,
  output rmn_pkg::rmn_job_t head,
  output rmn_pkg::rmn_qstat_t stat
);

  rmn_pkg::rmn_job_t                  slot_r [rmn_pkg::QDEPTH];
  logic [rmn_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [rmn_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [rmn_pkg::QCNT_W-1:0]         count_r, count_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? rmn_pkg::QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rmn_pkg::QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = rmn_pkg::QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = rmn_pkg::QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == rmn_pkg::QCNT_W'(rmn_pkg::QDEPTH));

endmodule

// ===== src/rmn_front.sv =====
// Front part: accepts loads and fetches, keeps the frame store and statistics.
module rmn_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rmn_pkg::DATA_W-1:0]        in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  rmn_pkg::rmn_qstat_t               qstat,
  output logic                              push,
  output rmn_pkg::rmn_job_t                 push_data
);

  localparam int AW = rmn_pkg::ADDR_W;
  localparam int CW = rmn_pkg::CNT_W;
  localparam int NC = rmn_pkg::CHANNELS;
  localparam int PW = rmn_pkg::PIX_W;

  logic [rmn_pkg::DATA_W-1:0] store_r [rmn_pkg::MAX_PIXELS];
  logic [rmn_pkg::DATA_W-1:0] rdata_r;

  logic [CW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] pcount_r, pcount_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [NC-1:0][PW-1:0] run_lo_r, run_lo_nxt, run_hi_r, run_hi_nxt;
  logic [NC-1:0][PW-1:0] img_lo_r, img_lo_nxt, img_hi_r, img_hi_nxt;
  logic [NC-1:0][PW-1:0] upd_lo, upd_hi;
  logic [NC-1:0][PW-1:0] pix;

  logic          s1_valid_r, s1_last_r, s1_last_nxt;
  logic [NC-1:0][PW-1:0] s1_lo_r, s1_hi_r;
  logic          accept, is_load, wr_en, fetch_go, last_px;
  logic [CW-1:0] wp_inc;

  // Leave room in the queue for the fetch still reading the store
  assign in_tready = (rmn_pkg::QCNT_W'(qstat.count + rmn_pkg::QCNT_W'(s1_valid_r))
                      < rmn_pkg::QCNT_W'(rmn_pkg::QDEPTH));
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == rmn_pkg::OP_LOAD);
  assign wr_en     = accept && is_load && (wp_r < CW'(rmn_pkg::MAX_PIXELS));
  assign fetch_go  = accept && !is_load && (pcount_r != '0);
  assign pix       = in_tdata;
  assign last_px   = (CW'({1'b0, rp_r} + 1'b1) >= pcount_r);
  assign wp_inc    = CW'(wp_r + 1'b1);

  // Classify the transaction and update pointers and statistics
  always_comb begin
    wp_nxt      = wp_r;
    pcount_nxt  = pcount_r;
    rp_nxt      = rp_r;
    run_lo_nxt  = run_lo_r;
    run_hi_nxt  = run_hi_r;
    img_lo_nxt  = img_lo_r;
    img_hi_nxt  = img_hi_r;
    s1_last_nxt = s1_last_r;
    for (int c = 0; c < NC; c++) begin
      upd_lo[c] = (wr_en && pix[c] < run_lo_r[c]) ? pix[c] : run_lo_r[c];
      upd_hi[c] = (wr_en && pix[c] > run_hi_r[c]) ? pix[c] : run_hi_r[c];
    end
    if (accept && is_load) begin
      wp_nxt     = wr_en ? wp_inc : wp_r;
      run_lo_nxt = upd_lo;
      run_hi_nxt = upd_hi;
      if (in_tlast) begin
        // Close the image
        pcount_nxt = wr_en ? wp_inc : wp_r;
        img_lo_nxt = upd_lo;
        img_hi_nxt = upd_hi;
        run_lo_nxt = {NC{rmn_pkg::CH_FULL}};
        run_hi_nxt = '0;
        wp_nxt     = '0;
        rp_nxt     = '0;
      end
    end
    if (fetch_go) begin
      s1_last_nxt = last_px;
      rp_nxt      = last_px ? '0 : AW'(rp_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      pcount_r   <= '0;
      rp_r       <= '0;
      run_lo_r   <= {NC{rmn_pkg::CH_FULL}};
      run_hi_r   <= '0;
      img_lo_r   <= '0;
      img_hi_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      pcount_r   <= pcount_nxt;
      rp_r       <= rp_nxt;
      run_lo_r   <= run_lo_nxt;
      run_hi_r   <= run_hi_nxt;
      img_lo_r   <= img_lo_nxt;
      img_hi_r   <= img_hi_nxt;
      s1_valid_r <= fetch_go;
    end
  end

  // Write the frame store and register the fetch read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wp_r[AW-1:0]] <= in_tdata;
    end
    if (fetch_go) begin
      rdata_r <= store_r[rp_r];
      s1_lo_r <= img_lo_r;
      s1_hi_r <= img_hi_r;
    end
    s1_last_r <= s1_last_nxt;
  end

  // Hand the fetched pixel to the queue
  assign push           = s1_valid_r;
  assign push_data.last = s1_last_r;
  assign push_data.v    = rdata_r;
  assign push_data.lo   = s1_lo_r;
  assign push_data.hi   = s1_hi_r;

endmodule

// ===== src/rmn_back.sv =====
// Back part: stretches each channel with a bit-serial divider per lane.
module rmn_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmn_pkg::rmn_job_t            head,
  input  rmn_pkg::rmn_qstat_t          qstat,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rmn_pkg::DATA_W-1:0]   out_tdata,
  output logic                         out_tlast
);

  localparam int NC = rmn_pkg::CHANNELS;
  localparam int PW = rmn_pkg::PIX_W;
  localparam int SW = rmn_pkg::STEP_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [NC-1:0][PW-1:0] rem_r, rem_nxt, num_r, num_nxt, div_r, div_nxt, quo_r, quo_nxt;
  logic [NC-1:0][PW-1:0] byp_val_r, byp_val_nxt;
  logic [NC-1:0]         byp_r, byp_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [NC-1:0][PW-1:0] out_data_r, out_data_nxt;
  logic [NC-1:0][PW-1:0] diff;
  logic [NC-1:0][2*PW-1:0] prod;
  logic [NC-1:0][PW:0]   trial;
  logic                  slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign pop       = (state_r == B_IDLE) && !qstat.empty;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    byp_nxt       = byp_r;
    byp_val_nxt   = byp_val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    for (int c = 0; c < NC; c++) begin
      diff[c]  = PW'(head.v[c] - head.lo[c]);
      // 255 * diff as shift and subtract
      prod[c]  = (2*PW)'({diff[c], {PW{1'b0}}} - {{PW{1'b0}}, diff[c]});
      trial[c] = {rem_r[c], num_r[c][PW-1]};
    end
    unique case (state_r)
      B_IDLE: begin
        if (pop) begin
          // Set up each lane: trivial cases bypass the divider
          for (int c = 0; c < NC; c++) begin
            byp_nxt[c]     = 1'b1;
            byp_val_nxt[c] = '0;
            if (head.lo[c] >= head.hi[c]) begin
              byp_val_nxt[c] = head.v[c];
            end else if (head.v[c] <= head.lo[c]) begin
              byp_val_nxt[c] = '0;
            end else if (head.v[c] >= head.hi[c]) begin
              byp_val_nxt[c] = rmn_pkg::CH_FULL;
            end else begin
              byp_nxt[c] = 1'b0;
            end
            rem_nxt[c] = prod[c][2*PW-1:PW];
            num_nxt[c] = prod[c][PW-1:0];
            div_nxt[c] = PW'(head.hi[c] - head.lo[c]);
            quo_nxt[c] = '0;
          end
          last_nxt  = head.last;
          step_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        // One quotient bit per lane per cycle
        for (int c = 0; c < NC; c++) begin
          if (trial[c] >= {1'b0, div_r[c]}) begin
            rem_nxt[c] = PW'(trial[c] - {1'b0, div_r[c]});
            quo_nxt[c] = {quo_r[c][PW-2:0], 1'b1};
          end else begin
            rem_nxt[c] = trial[c][PW-1:0];
            quo_nxt[c] = {quo_r[c][PW-2:0], 1'b0};
          end
          num_nxt[c] = {num_r[c][PW-2:0], 1'b0};
        end
        step_nxt = SW'(step_r + 1'b1);
        if (step_r == SW'(rmn_pkg::DIV_STEPS - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        // Hold until the output register frees up
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r;
          for (int c = 0; c < NC; c++) begin
            out_data_nxt[c] = byp_r[c] ? byp_val_r[c] : quo_r[c];
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    num_r      <= num_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    byp_r      <= byp_nxt;
    byp_val_r  <= byp_val_nxt;
    last_r     <= last_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/rgb_min_max_normalizer.sv =====
// A stream of loads runs at one pixel per cycle while in_tready is high.
// A fetch reads the store into a register and enters the queue; the back part
// then pops it in a setup state, runs its bit-serial divider lanes one quotient
// bit per step and writes the output register before it pops the next fetch.
// Reset (rst_n low, synchronous) empties the queue and output and clears the
// pointers and statistics; frame store contents are kept and undefined.
`include "rgb_min_max_normalizer_assert.svh"

module rgb_min_max_normalizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rmn_pkg::DATA_W-1:0]       in_tdata,  // red_in, green_in, blue_in
  input  logic                             in_tuser,  // operation
  input  logic                             in_tlast,  // final_pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rmn_pkg::DATA_W-1:0]       out_tdata, // red_out, green_out, blue_out
  output logic                             out_tlast  // end_of_image
);

  rmn_pkg::rmn_job_t   push_data, head;
  rmn_pkg::rmn_qstat_t qstat;
  logic                push, pop;

  rmn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  rmn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  rmn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Queue never overruns or underruns, and a pop starts the back part
  `RMN_ASSERT_NOW(a_no_overrun, clk, rst_n, push, !qstat.full || pop)
  `RMN_ASSERT_NOW(a_no_underrun, clk, rst_n, pop, !qstat.empty)
  `RMN_ASSERT_NEXT(a_pop_busy, clk, rst_n, pop, !pop)

endmodule
